/* sv/polar_target_point_converter_top_macros.svh */
// assertion macros shared by the checker of the target point converter
// no dependencies
`ifndef POLAR_TARGET_POINT_CONVERTER_TOP_MACROS_SVH
`define POLAR_TARGET_POINT_CONVERTER_TOP_MACROS_SVH

// property checked outside reset
`define PTPC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// property checked on every edge, reset included
`define PTPC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

/* sv/ptpc_pkg.sv */
// types, constants and tables of the polar target point converter
// used by every module of the block; no dependencies
package ptpc_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int EPS           = (1 << FRAC_BITS) / 1000000;
  localparam int QSH           = FRAC_BITS + 16 - 23;
  localparam int CW            = 56;
  localparam int ZW            = 34;
  localparam int SHW           = 5;

  localparam logic [45:0] TURN_RAD = 46'd44798133900177;
  localparam logic [45:0] TURN_DEG = 46'd781874935307;
  localparam logic [29:0] GAIN     = 30'd652032874;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam int MODE_PREFER_XY = 0;
  localparam int MODE_DEGREES   = 1;
  localparam int MODE_INVERT_Y  = 2;
  localparam int MODE_REQ_STATE = 3;

  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_ANGLE    = 3'd1;
  localparam logic [2:0] CFG_ANCHOR_X = 3'd2;
  localparam logic [2:0] CFG_ANCHOR_Y = 3'd3;
  localparam logic [2:0] CFG_MIN_DIST = 3'd4;
  localparam logic [2:0] CFG_MAX_DIST = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_STATE = 2'd1;
  localparam logic [1:0] STATUS_NO_SOURCE = 2'd2;
  localparam logic [1:0] STATUS_RANGE     = 2'd3;

  typedef enum logic [1:0] {
    KIND_BAD_STATE,
    KIND_XY,
    KIND_POLAR,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [18:0] aoff;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic [22:0]        dmin;
    logic [22:0]        dmax;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] sx;
    logic signed [24:0] sy;
    logic               flip;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    side_t                side;
  } cdat_t;

endpackage

/* sv/polar_target_point_converter_top.sv */
// Polar/Cartesian target point converter. Takes one sensor report per cycle while in_ready
// is high and returns one target point per report, in order. It has 5 front stages (source
// choice, bearing to turns, offset, half-turn fold), one cell per CORDIC stage (18), and 4
// back stages (rounding, anchor offset with saturation, squares, distance check). While
// out_ready holds high, throughput is one transaction per cycle; every stage holds its
// own valid bit, so in_ready stays high while empty stages remain between input and a
// stalled output. Configuration writes are taken at once (cfg_ready is always high) and
// must only happen while the block holds no transaction.
// depends on ptpc_pkg, ptpc_front, ptpc_cell, ptpc_back
module polar_target_point_converter_top import ptpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [7:0]  in_device_state,
  input  logic               in_xy_ok,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic               in_polar_ok,
  input  logic [22:0]        in_range_m,
  input  logic signed [27:0] in_bearing,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_used_polar,
  output logic signed [23:0] out_target_x,
  output logic signed [23:0] out_target_y
);

  cfg_t  cfg_r;
  cdat_t c_dat [CORDIC_STAGES+1];
  logic  c_v   [CORDIC_STAGES+1];
  logic  c_rdy [CORDIC_STAGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= 4'd9;
      cfg_r.aoff <= '0;
      cfg_r.ax   <= '0;
      cfg_r.ay   <= '0;
      cfg_r.dmin <= '0;
      cfg_r.dmax <= 23'd524288;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:     cfg_r.mode <= cfg_data[3:0];
        CFG_ANGLE:    cfg_r.aoff <= $signed(cfg_data[18:0]);
        CFG_ANCHOR_X: cfg_r.ax   <= $signed(cfg_data);
        CFG_ANCHOR_Y: cfg_r.ay   <= $signed(cfg_data);
        CFG_MIN_DIST: cfg_r.dmin <= cfg_data[22:0];
        CFG_MAX_DIST: cfg_r.dmax <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  ptpc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_device_state (in_device_state),
    .in_xy_ok        (in_xy_ok),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_polar_ok     (in_polar_ok),
    .in_range_m      (in_range_m),
    .in_bearing      (in_bearing),
    .out_valid       (c_v[0]),
    .out_ready       (c_rdy[0]),
    .out_dat         (c_dat[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    ptpc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (SHW'(k)),
      .atan      (ATAN_TURNS[k]),
      .in_valid  (c_v[k]),
      .in_ready  (c_rdy[k]),
      .in_dat    (c_dat[k]),
      .out_valid (c_v[k+1]),
      .out_ready (c_rdy[k+1]),
      .out_dat   (c_dat[k+1])
    );
  end

  ptpc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (c_v[CORDIC_STAGES]),
    .in_ready       (c_rdy[CORDIC_STAGES]),
    .in_dat         (c_dat[CORDIC_STAGES]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_used_polar (out_used_polar),
    .out_target_x   (out_target_x),
    .out_target_y   (out_target_y)
  );

endmodule

/* sv/ptpc_cell.sv */
// one cordic rotation cell with its own output register
// depends on ptpc_pkg
module ptpc_cell import ptpc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [SHW-1:0] shift,
  input  logic [31:0]    atan,
  input  logic           in_valid,
  output logic           in_ready,
  input  cdat_t          in_dat,
  output logic           out_valid,
  input  logic           out_ready,
  output cdat_t          out_dat
);

  logic                 v_r;
  cdat_t                dat_r;
  cdat_t                dat_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] da;
  logic                 en;

  assign en       = !v_r || out_ready;
  assign in_ready = en;
  assign dx = in_dat.y >>> shift;
  assign dy = in_dat.x >>> shift;
  assign da = $signed({{(ZW-32){1'b0}}, atan});

  always_comb begin
    dat_nxt = in_dat;
    if (!in_dat.z[ZW-1]) begin
      dat_nxt.x = in_dat.x - dx;
      dat_nxt.y = in_dat.y + dy;
      dat_nxt.z = in_dat.z - da;
    end else begin
      dat_nxt.x = in_dat.x + dx;
      dat_nxt.y = in_dat.y - dy;
      dat_nxt.z = in_dat.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      dat_r <= dat_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_dat   = dat_r;

endmodule

/* sv/ptpc_front.sv */
// source selection and angle path: turns, offset, half-turn fold, cordic seed
// depends on ptpc_pkg
module ptpc_front import ptpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [7:0]  in_device_state,
  input  logic               in_xy_ok,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic               in_polar_ok,
  input  logic [22:0]        in_range_m,
  input  logic signed [27:0] in_bearing,
  output logic               out_valid,
  input  logic               out_ready,
  output cdat_t              out_dat
);

  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1: captured transaction
  logic signed [7:0]  st1_r;
  logic               xyok1_r, pok1_r;
  logic signed [23:0] px1_r, py1_r;
  logic [22:0]        rng1_r;
  logic signed [27:0] brg1_r;

  // stage 2: decision and magnitudes
  side_t       side2_r, side2_nxt;
  logic [27:0] magb2_r;
  logic        negb2_r;
  logic [18:0] mago2_r;
  logic        nego2_r;
  logic [22:0] rng2_r;
  logic        away, use_polar, bad_state;

  // stage 3: partial products
  side_t           side3_r;
  logic [50:0]     pbh3_r, pbl3_r;
  logic [41:0]     poh3_r, pol3_r;
  logic            negb3_r, nego3_r;
  logic [CW-1:0]   x03_r;
  logic [45:0]     cb;

  // stage 4: turns
  side_t         side4_r;
  logic [31:0]   qb4_r, qo4_r;
  logic [CW-1:0] x04_r;
  logic [51:0]   pb0, po0, sb, so;
  logic [31:0]   qbu, qou;

  // stage 5: folded angle
  cdat_t       dat5_r;
  logic [31:0] t, tu, w;
  logic        flip;

  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      st1_r   <= in_device_state;
      xyok1_r <= in_xy_ok;
      px1_r   <= in_pos_x;
      py1_r   <= in_pos_y;
      pok1_r  <= in_polar_ok;
      rng1_r  <= in_range_m;
      brg1_r  <= in_bearing;
    end
  end

  assign away      = xyok1_r && ((px1_r != 24'sd0) || (py1_r != 24'sd0));
  assign use_polar = pok1_r && ({9'd0, rng1_r} > 32'(EPS));
  assign bad_state = cfg.mode[MODE_REQ_STATE] && st1_r[7];

  always_comb begin
    side2_nxt.sx   = px1_r;
    side2_nxt.sy   = cfg.mode[MODE_INVERT_Y] ? -25'(py1_r) : 25'(py1_r);
    side2_nxt.flip = 1'b0;
    if (bad_state) begin
      side2_nxt.kind = KIND_BAD_STATE;
    end else if ((cfg.mode[MODE_PREFER_XY] && away) || (!use_polar && xyok1_r)) begin
      side2_nxt.kind = KIND_XY;
    end else if (use_polar) begin
      side2_nxt.kind = KIND_POLAR;
    end else begin
      side2_nxt.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      side2_r <= side2_nxt;
      magb2_r <= brg1_r[27] ? 28'(-brg1_r) : 28'(brg1_r);
      negb2_r <= brg1_r[27];
      mago2_r <= cfg.aoff[18] ? 19'(-cfg.aoff) : 19'(cfg.aoff);
      nego2_r <= cfg.aoff[18];
      rng2_r  <= rng1_r;
    end
  end

  assign cb = cfg.mode[MODE_DEGREES] ? TURN_DEG : TURN_RAD;

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      side3_r <= side2_r;
      pbh3_r  <= 51'(magb2_r) * 51'(cb[45:23]);
      pbl3_r  <= 51'(magb2_r) * 51'(cb[22:0]);
      poh3_r  <= 42'(mago2_r) * 42'(TURN_RAD[45:23]);
      pol3_r  <= 42'(mago2_r) * 42'(TURN_RAD[22:0]);
      negb3_r <= negb2_r;
      nego3_r <= nego2_r;
      x03_r   <= CW'(rng2_r) * CW'(GAIN);
    end
  end

  assign pb0 = 52'(pbl3_r) + (52'd1 << (FRAC_BITS + 15));
  assign po0 = 52'(pol3_r) + (52'd1 << (FRAC_BITS + 15));
  assign sb  = 52'(pbh3_r) + (pb0 >> 23);
  assign so  = 52'(poh3_r) + (po0 >> 23);
  assign qbu = 32'(sb >> QSH);
  assign qou = 32'(so >> QSH);

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      side4_r <= side3_r;
      qb4_r   <= negb3_r ? -qbu : qbu;
      qo4_r   <= nego3_r ? -qou : qou;
      x04_r   <= x03_r;
    end
  end

  assign t    = qb4_r + qo4_r;
  assign w    = t + 32'h4000_0000;
  assign flip = w[31];
  assign tu   = flip ? (t + 32'h8000_0000) : t;

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      dat5_r.x    <= $signed(x04_r);
      dat5_r.y    <= '0;
      dat5_r.z    <= $signed({2'b00, tu + 32'h4000_0000}) - $signed(ZW'(32'h4000_0000));
      dat5_r.side <= '{side4_r.kind, side4_r.sx, side4_r.sy, flip};
    end
  end

  assign out_valid = v5_r;
  assign out_dat   = dat5_r;

endmodule

/* sv/ptpc_back.sv */
// rounding, source merge, anchor offset with saturation, distance check
// depends on ptpc_pkg
module ptpc_back import ptpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdat_t              in_dat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_used_polar,
  output logic signed [23:0] out_target_x,
  output logic signed [23:0] out_target_y
);

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [CW-1:0] xs, ys;
  logic signed [25:0]   xr, yr, vx, vy;
  logic                 yneg;
  logic signed [25:0]   vx1_r, vy1_r;
  kind_t                kind1_r, kind2_r, kind3_r;

  logic signed [26:0] sumx, sumy;
  logic signed [23:0] satx, saty;
  logic signed [23:0] tx2_r, ty2_r, tx3_r, ty3_r;
  logic signed [47:0] txe, tye;
  logic [47:0]        sqx3_r, sqy3_r, mn3_r, mx3_r;
  logic [48:0]        d2;

  logic [1:0]         status4_r;
  logic               polar4_r;
  logic signed [23:0] tx4_r, ty4_r;

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  assign xs   = in_dat.x + (CW'(1) <<< 29);
  assign ys   = in_dat.y + (CW'(1) <<< 29);
  assign xr   = 26'(xs >>> 30);
  assign yr   = 26'(ys >>> 30);
  assign yneg = in_dat.side.flip ^ cfg.mode[MODE_INVERT_Y];
  assign vx   = (in_dat.side.kind == KIND_POLAR) ? (in_dat.side.flip ? -xr : xr)
                                                 : 26'(in_dat.side.sx);
  assign vy   = (in_dat.side.kind == KIND_POLAR) ? (yneg ? -yr : yr)
                                                 : 26'(in_dat.side.sy);

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      vx1_r   <= vx;
      vy1_r   <= vy;
      kind1_r <= in_dat.side.kind;
    end
  end

  assign sumx = 27'(vx1_r) + 27'(cfg.ax);
  assign sumy = 27'(vy1_r) + 27'(cfg.ay);
  assign satx = (sumx > 27'sd8388607) ? 24'sd8388607 :
                (sumx < -27'sd8388608) ? -24'sd8388608 : 24'(sumx);
  assign saty = (sumy > 27'sd8388607) ? 24'sd8388607 :
                (sumy < -27'sd8388608) ? -24'sd8388608 : 24'(sumy);

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      kind2_r <= kind1_r;
      if ((kind1_r == KIND_XY) || (kind1_r == KIND_POLAR)) begin
        tx2_r <= satx;
        ty2_r <= saty;
      end else begin
        tx2_r <= '0;
        ty2_r <= '0;
      end
    end
  end

  assign txe = 48'(tx2_r);
  assign tye = 48'(ty2_r);

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      kind3_r <= kind2_r;
      tx3_r   <= tx2_r;
      ty3_r   <= ty2_r;
      sqx3_r  <= 48'(txe * txe);
      sqy3_r  <= 48'(tye * tye);
      mn3_r   <= 48'(cfg.dmin) * 48'(cfg.dmin);
      mx3_r   <= 48'(cfg.dmax) * 48'(cfg.dmax);
    end
  end

  assign d2 = 49'(sqx3_r) + 49'(sqy3_r);

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      tx4_r    <= tx3_r;
      ty4_r    <= ty3_r;
      polar4_r <= (kind3_r == KIND_POLAR);
      case (kind3_r)
        KIND_BAD_STATE: status4_r <= STATUS_BAD_STATE;
        KIND_NONE:      status4_r <= STATUS_NO_SOURCE;
        default: begin
          if ((d2 < 49'(mn3_r)) || (d2 > 49'(mx3_r))) begin
            status4_r <= STATUS_RANGE;
          end else begin
            status4_r <= STATUS_OK;
          end
        end
      endcase
    end
  end

  assign out_valid      = v4_r;
  assign out_status     = status4_r;
  assign out_used_polar = polar4_r;
  assign out_target_x   = tx4_r;
  assign out_target_y   = ty4_r;

endmodule

/* sv/ptpc_checker.sv */
// port-level checks of the target point converter and their bind
// depends on ptpc_pkg and polar_target_point_converter_top_macros.svh
`include "polar_target_point_converter_top_macros.svh"

module ptpc_checker import ptpc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic               out_used_polar,
  input logic signed [23:0] out_target_x,
  input logic signed [23:0] out_target_y
);

  logic reject_st;
  logic zero_pt;

  assign reject_st = (out_status == STATUS_BAD_STATE) || (out_status == STATUS_NO_SOURCE);
  assign zero_pt   = (out_target_x == 24'sd0) && (out_target_y == 24'sd0) && !out_used_polar;

  `PTPC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  `PTPC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  `PTPC_ASSERT(a_reject_zero, clk, rst_n, out_valid && reject_st |-> zero_pt)

  `PTPC_ASSERT(a_polar_ok, clk, rst_n, out_valid && out_used_polar |-> !reject_st)

endmodule

bind polar_target_point_converter_top ptpc_checker u_ptpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_used_polar (out_used_polar),
  .out_target_x   (out_target_x),
  .out_target_y   (out_target_y)
);
